@@ src/rbsi_pkg.sv @@
// ----------------------------------------------------------------------------
// rbsi_pkg: shared types and constants for the ray/box slab intersection unit
// Fixed-point widths, register map and the beat payload structs.
// ----------------------------------------------------------------------------
`default_nettype none

package rbsi_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int NUM_AXES    = 3;
  localparam int ENTRY_W     = COORD_WIDTH - 1;
  // corner minus origin needs one extra bit, the product the sum of both operand widths
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = DIFF_W + COORD_WIDTH;
  localparam int SHIFT_W     = PROD_W - FRAC_BITS;

  localparam int NUM_REGS    = 2 * NUM_AXES;
  localparam int REG_IDX_W   = $clog2(NUM_REGS);
  localparam int ADDR_W      = REG_IDX_W + 2;
  localparam int DATA_W      = 32;

  localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_X = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_Y = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_Z = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_X = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_Y = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_Z = REG_IDX_W'(5);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t inv_dir_x;
    coord_t inv_dir_y;
    coord_t inv_dir_z;
  } ray_item_t;

  typedef struct packed {
    logic               hit;
    logic [ENTRY_W-1:0] entry_distance;
  } hit_item_t;

  // per-axis slab interval after saturation
  typedef struct packed {
    coord_t lo;
    coord_t hi;
  } slab_range_t;

  // pipeline stage load enables from the handshake control
  typedef struct packed {
    logic en_s1;
    logic en_s2;
    logic en_s3;
  } stage_ctrl_t;

endpackage

`default_nettype wire

@@ src/ray_box_slab_intersect_unit.sv @@
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_unit: ray versus axis-aligned box slab test
// Box corners from an APB register file, one ray beat in, one hit beat out.
// ----------------------------------------------------------------------------
// Takes one ray beat per cycle while in_ready_o is high and presents its result
// beat once the beat has passed the lane stages and the merge register. Three
// axis lanes run side by side, each with two 33x32 multipliers registered on
// both sides; that multiply stage sets the four-stage depth. Every stage holds
// a valid bit and loads whenever the stage after it is empty or moving, so
// bubbles close up under back-pressure. Box corners are written over APB (no
// wait states) and must only change while no ray is in flight.
`default_nettype none

module ray_box_slab_intersect_unit
  import rbsi_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire ray_item_t         in_data_i,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      hit_item_t         out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output      logic [DATA_W-1:0] prdata,
  output      logic              pready
);

  coord_t      box_min_q [NUM_AXES];
  coord_t      box_max_q [NUM_AXES];
  logic [REG_IDX_W-1:0] reg_idx;
  logic        cfg_wr;

  logic        v1_q, v2_q, v3_q, vout_q;
  logic        rdy1, rdy2, rdy3, rdy_out;
  stage_ctrl_t ctrl;
  slab_range_t slab [NUM_AXES];
  coord_t      origin [NUM_AXES];
  coord_t      inv_dir [NUM_AXES];

  // ---- register file
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        box_min_q[a] <= '0;
        box_max_q[a] <= '0;
      end
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BOX_MIN_X: box_min_q[0] <= pwdata[COORD_WIDTH-1:0];
        REG_BOX_MIN_Y: box_min_q[1] <= pwdata[COORD_WIDTH-1:0];
        REG_BOX_MIN_Z: box_min_q[2] <= pwdata[COORD_WIDTH-1:0];
        REG_BOX_MAX_X: box_max_q[0] <= pwdata[COORD_WIDTH-1:0];
        REG_BOX_MAX_Y: box_max_q[1] <= pwdata[COORD_WIDTH-1:0];
        REG_BOX_MAX_Z: box_max_q[2] <= pwdata[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BOX_MIN_X: prdata = box_min_q[0];
      REG_BOX_MIN_Y: prdata = box_min_q[1];
      REG_BOX_MIN_Z: prdata = box_min_q[2];
      REG_BOX_MAX_X: prdata = box_max_q[0];
      REG_BOX_MAX_Y: prdata = box_max_q[1];
      REG_BOX_MAX_Z: prdata = box_max_q[2];
      default:       prdata = '0;
    endcase
  end

  // ---- stage handshake
  assign rdy_out    = !vout_q || out_ready_i;
  assign rdy3       = !v3_q || rdy_out;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  assign ctrl.en_s1 = in_valid_i && rdy1;
  assign ctrl.en_s2 = v1_q && rdy2;
  assign ctrl.en_s3 = v2_q && rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      vout_q <= 1'b0;
    end else begin
      if (rdy1)    v1_q   <= in_valid_i;
      if (rdy2)    v2_q   <= v1_q;
      if (rdy3)    v3_q   <= v2_q;
      if (rdy_out) vout_q <= v3_q;
    end
  end

  // ---- axis lanes
  assign origin[0]  = in_data_i.origin_x;
  assign origin[1]  = in_data_i.origin_y;
  assign origin[2]  = in_data_i.origin_z;
  assign inv_dir[0] = in_data_i.inv_dir_x;
  assign inv_dir[1] = in_data_i.inv_dir_y;
  assign inv_dir[2] = in_data_i.inv_dir_z;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    rbsi_lane u_lane (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .corner_a_i (box_min_q[a]),
      .corner_b_i (box_max_q[a]),
      .origin_i   (origin[a]),
      .inv_dir_i  (inv_dir[a]),
      .slab_o     (slab[a])
    );
  end

  rbsi_merge u_merge (
    .clk_i    (clk_i),
    .en_i     (v3_q && rdy_out),
    .slab_i   (slab),
    .result_o (out_data_o)
  );

  assign out_valid_o = vout_q;

  // ---- checks
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v1_q)
    else $error("accepted ray beat did not enter first stage");

  a_stalled_s3_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !rdy_out |=> v3_q)
    else $error("stalled merge-input stage lost its beat");

  a_cfg_write_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && reg_idx == REG_BOX_MAX_Z |=> box_max_q[2] == $past(pwdata[COORD_WIDTH-1:0]))
    else $error("box corner write not taken");

  a_miss_zero_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.entry_distance != '0 |-> out_data_o.hit)
    else $error("entry distance on a miss");

endmodule

`default_nettype wire

@@ src/rbsi_lane.sv @@
// ----------------------------------------------------------------------------
// rbsi_lane: one axis of the slab test
// Subtract, multiply by inverse direction, floor-shift, saturate, order.
// ----------------------------------------------------------------------------
`default_nettype none

module rbsi_lane
  import rbsi_pkg::*;
(
  input  wire logic        clk_i,
  input  wire stage_ctrl_t ctrl_i,
  input  wire coord_t      corner_a_i,
  input  wire coord_t      corner_b_i,
  input  wire coord_t      origin_i,
  input  wire coord_t      inv_dir_i,
  output slab_range_t      slab_o
);

  logic signed [DIFF_W-1:0]  diff_a_d, diff_a_q, diff_b_d, diff_b_q;
  coord_t                    inv_q;
  logic signed [PROD_W-1:0]  prod_a_d, prod_a_q, prod_b_d, prod_b_q;
  logic signed [SHIFT_W-1:0] shr_a, shr_b;
  coord_t                    t_a, t_b;
  slab_range_t               slab_d, slab_q;

  function automatic coord_t sat_coord(input logic signed [SHIFT_W-1:0] v);
    logic [SHIFT_W-COORD_WIDTH:0] top;
    coord_t                       res;
    top = v[SHIFT_W-1:COORD_WIDTH-1];
    if ((&top) || !(|top)) begin
      res = v[COORD_WIDTH-1:0];
    end else if (v[SHIFT_W-1]) begin
      res = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
    return res;
  endfunction

  always_comb begin
    diff_a_d = {corner_a_i[COORD_WIDTH-1], corner_a_i} - {origin_i[COORD_WIDTH-1], origin_i};
    diff_b_d = {corner_b_i[COORD_WIDTH-1], corner_b_i} - {origin_i[COORD_WIDTH-1], origin_i};
  end

  // both operands sign-extended to full width, so the low bits are the signed product
  always_comb begin
    prod_a_d = {{(PROD_W-DIFF_W){diff_a_q[DIFF_W-1]}}, diff_a_q}
             * {{(PROD_W-COORD_WIDTH){inv_q[COORD_WIDTH-1]}}, inv_q};
    prod_b_d = {{(PROD_W-DIFF_W){diff_b_q[DIFF_W-1]}}, diff_b_q}
             * {{(PROD_W-COORD_WIDTH){inv_q[COORD_WIDTH-1]}}, inv_q};
  end

  // arithmetic drop of the fraction bits is a floor
  always_comb begin
    shr_a     = prod_a_q[PROD_W-1:FRAC_BITS];
    shr_b     = prod_b_q[PROD_W-1:FRAC_BITS];
    t_a       = sat_coord(shr_a);
    t_b       = sat_coord(shr_b);
    slab_d.lo = (t_a < t_b) ? t_a : t_b;
    slab_d.hi = (t_a < t_b) ? t_b : t_a;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_s1) begin
      diff_a_q <= diff_a_d;
      diff_b_q <= diff_b_d;
      inv_q    <= inv_dir_i;
    end
    if (ctrl_i.en_s2) begin
      prod_a_q <= prod_a_d;
      prod_b_q <= prod_b_d;
    end
    if (ctrl_i.en_s3) begin
      slab_q <= slab_d;
    end
  end

  assign slab_o = slab_q;

endmodule

`default_nettype wire

@@ src/rbsi_merge.sv @@
// ----------------------------------------------------------------------------
// rbsi_merge: combine the three axis intervals into the hit result
// Near is the largest lower bound, far the smallest upper bound.
// ----------------------------------------------------------------------------
`default_nettype none

module rbsi_merge
  import rbsi_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire slab_range_t slab_i [NUM_AXES],
  output hit_item_t        result_o
);

  coord_t    near_t, far_t;
  hit_item_t result_d, result_q;

  always_comb begin
    near_t = slab_i[0].lo;
    far_t  = slab_i[0].hi;
    for (int a = 1; a < NUM_AXES; a++) begin
      if (slab_i[a].lo > near_t) begin
        near_t = slab_i[a].lo;
      end
      if (slab_i[a].hi < far_t) begin
        far_t = slab_i[a].hi;
      end
    end
    result_d.hit = (far_t >= near_t) && !far_t[COORD_WIDTH-1];
    // origin inside the box gives a negative near, reported as zero
    if (result_d.hit && !near_t[COORD_WIDTH-1]) begin
      result_d.entry_distance = near_t[ENTRY_W-1:0];
    end else begin
      result_d.entry_distance = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

`default_nettype wire
